// File: design/mcts_pkg.sv
// ----------------------------------------------------------------------------
// Motion command time scaler package
// Widths, register indexes and the shared command record type.
// ----------------------------------------------------------------------------
package mcts_pkg;

   localparam int STAMP_W   = 31;
   localparam int DATA_W    = 32;
   localparam int SCALE_W   = 12;
   localparam int DEV_W     = 3;
   localparam int STEP_W    = 4;
   localparam int DIV_W     = 36;
   localparam int MUL_A_W   = 33;
   localparam int MUL_B_W   = 13;
   localparam int PROD_W    = MUL_A_W + MUL_B_W;
   localparam int ACC_W     = 40;

   localparam logic [SCALE_W-1:0] SCALE_MAX = 12'd2048;

   localparam logic CSR_SCALE  = 1'b0;
   localparam logic CSR_INTERP = 1'b1;

   typedef struct packed {
      logic [DATA_W-1:0] stamp;
      logic [DATA_W-1:0] angle;
   } cmd_type;

endpackage

// File: design/mcts_div.sv
// ----------------------------------------------------------------------------
// Motion command time scaler divider
// Restoring divider, one quotient bit per cycle, small unsigned divisor.
// ----------------------------------------------------------------------------
module mcts_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [mcts_pkg::DIV_W-1:0]       dividend,
   input  logic [mcts_pkg::STEP_W-1:0]      divisor,
   output logic                             done,
   output logic [mcts_pkg::DIV_W-1:0]       quotient
);

   localparam int CNT_W = $clog2(mcts_pkg::DIV_W + 1);

   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;
   logic [CNT_W-1:0]                cnt_ff, cnt_in;
   logic [mcts_pkg::DIV_W-1:0]      quo_ff, quo_in;
   logic [mcts_pkg::STEP_W-1:0]     dsr_ff, dsr_in;
   logic [mcts_pkg::STEP_W:0]       rem_ff, rem_in;
   logic [mcts_pkg::STEP_W:0]       trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      rem_in  = rem_ff;
      trial   = {rem_ff[mcts_pkg::STEP_W-1:0], quo_ff[mcts_pkg::DIV_W-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         // The remainder stays below the divisor, so one compare suffices.
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = trial - {1'b0, dsr_ff};
            quo_in = {quo_ff[mcts_pkg::DIV_W-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[mcts_pkg::DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(mcts_pkg::DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
      rem_ff <= rem_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// File: design/motion_command_time_scaler.sv
// A missed start adds a second pass through the scaler for that command.
// A frame flush makes two divisions on the shared divider for each
// interpolated result, one for its stamp and one for its angle.
// One request is processed at a time; the result register lets the next
// request in while a result waits. Synchronous active-high reset clears
// all control state and restores scale 2.0 with interpolation off.
// ----------------------------------------------------------------------------
// Motion command time scaler
// Rebases and scales command times, with optional per-frame interpolation.
// ----------------------------------------------------------------------------
module motion_command_time_scaler #(
   parameter int DEVICES = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_mode,
   input  logic [mcts_pkg::DEV_W-1:0]         req_device_id,
   input  logic [mcts_pkg::STAMP_W-1:0]       req_stamp,
   input  logic signed [mcts_pkg::DATA_W-1:0] req_angle,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [mcts_pkg::DEV_W-1:0]         rsp_out_device,
   output logic signed [mcts_pkg::DATA_W-1:0] rsp_out_stamp,
   output logic signed [mcts_pkg::DATA_W-1:0] rsp_out_angle,
   output logic                               rsp_last_of_run,
   input  logic                               csr_write,
   input  logic                               csr_index,
   input  logic [mcts_pkg::SCALE_W-1:0]       csr_wdata
);

   localparam int ACT = (DEVICES < 8) ? DEVICES : 8;
   localparam int AW  = (ACT > 1) ? $clog2(ACT) : 1;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_DEC   = 4'd1;
   localparam logic [3:0] ST_SCALE = 4'd2;
   localparam logic [3:0] ST_SAT   = 4'd3;
   localparam logic [3:0] ST_SCAN  = 4'd4;
   localparam logic [3:0] ST_M1    = 4'd5;
   localparam logic [3:0] ST_M2    = 4'd6;
   localparam logic [3:0] ST_DIVS  = 4'd7;
   localparam logic [3:0] ST_DIVW  = 4'd8;
   localparam logic [3:0] ST_EMIT  = 4'd9;
   localparam logic [3:0] ST_NEXT  = 4'd10;
   localparam logic [3:0] ST_PEND  = 4'd11;

   localparam logic [1:0] PH_MISS = 2'd0;
   localparam logic [1:0] PH_EQ   = 2'd1;
   localparam logic [1:0] PH_NORM = 2'd2;

   localparam logic RET_DONE  = 1'b0;
   localparam logic RET_FLUSH = 1'b1;

   // Configuration.
   logic [mcts_pkg::SCALE_W-1:0] scale_ff;
   logic                         interp_ff;

   // Sequencer and request state.
   logic [3:0]                   state_ff, state_in;
   logic [mcts_pkg::DEV_W-1:0]   id_ff, id_in;
   logic [mcts_pkg::STAMP_W-1:0] stamp_ff, stamp_in;
   logic [mcts_pkg::DATA_W-1:0]  angle_ff, angle_in;
   logic [mcts_pkg::STAMP_W-1:0] start_ff, start_in;
   logic                         start_seen_ff, start_seen_in;
   logic [mcts_pkg::STAMP_W-1:0] init_ff, init_in;
   logic                         init_seen_ff, init_seen_in;
   logic [ACT-1:0]               prev_v_ff, prev_v_in;
   logic [ACT-1:0]               pend_v_ff, pend_v_in;
   logic [1:0]                   phase_ff, phase_in;
   logic [mcts_pkg::DATA_W-1:0]  ts_ff, ts_in;
   logic signed [mcts_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic signed [mcts_pkg::ACC_W-1:0]  acc_ff, acc_in;
   logic [mcts_pkg::STEP_W-1:0]  k_ff, k_in;
   logic [AW-1:0]                d_ff, d_in;
   logic                         fld_ff, fld_in;
   logic                         eos_ff, eos_in;
   logic                         ret_ff, ret_in;
   logic [mcts_pkg::DEV_W-1:0]   em_dev_ff, em_dev_in;
   logic [mcts_pkg::DATA_W-1:0]  em_st_ff, em_st_in;
   logic [mcts_pkg::DATA_W-1:0]  em_an_ff, em_an_in;
   logic                         em_last_ff, em_last_in;

   // Result register.
   logic                         rv_ff, rv_in;
   logic [mcts_pkg::DEV_W-1:0]   rdev_ff, rdev_in;
   logic [mcts_pkg::DATA_W-1:0]  rst_ff, rst_in;
   logic [mcts_pkg::DATA_W-1:0]  ran_ff, ran_in;
   logic                         rlast_ff, rlast_in;

   // Per-device command stores, read through a register addressed by the next scan index.
   mcts_pkg::cmd_type            prev_mem [ACT];
   mcts_pkg::cmd_type            pend_mem [ACT];
   logic                         prev_we, pend_we;
   logic [AW-1:0]                prev_wa, pend_wa;
   mcts_pkg::cmd_type            prev_wd, pend_wd;
   mcts_pkg::cmd_type            prev_rd_ff, pend_rd_ff;

   // Shared multiplier.
   logic signed [mcts_pkg::MUL_A_W-1:0] mul_a;
   logic signed [mcts_pkg::MUL_B_W-1:0] mul_b;
   logic signed [mcts_pkg::PROD_W-1:0]  mul_p;

   logic [mcts_pkg::SCALE_W-1:0] eff;
   logic [mcts_pkg::STEP_W-1:0]  s_int;
   logic                         final_pass;
   logic                         higher_pend;
   logic                         out_free;
   logic                         accept;
   logic [mcts_pkg::STAMP_W-1:0] scl_src;
   logic signed [mcts_pkg::PROD_W-1:0] rnd;
   logic signed [mcts_pkg::PROD_W-9:0] shq;
   logic [mcts_pkg::DATA_W-1:0]  sat;
   logic [mcts_pkg::STAMP_W-1:0] init_eff;
   logic                         acc_neg;
   logic [mcts_pkg::ACC_W-1:0]   acc_mag;
   logic                         div_start, div_done;
   logic [mcts_pkg::DIV_W-1:0]   div_q;
   logic [mcts_pkg::DIV_W-1:0]   div_sv;

   assign eff   = (scale_ff > mcts_pkg::SCALE_MAX) ? mcts_pkg::SCALE_MAX : scale_ff;
   assign s_int = eff[mcts_pkg::SCALE_W-1:8];
   assign final_pass = eos_ff || (k_ff >= s_int);
   assign out_free   = !rv_ff || !rsp_stall;
   assign req_stall  = (state_ff != ST_IDLE);
   assign accept     = req_valid && !req_stall;
   assign scl_src    = (phase_ff == PH_MISS) ? init_ff : stamp_ff;
   assign init_eff   = init_seen_ff ? init_ff : stamp_ff;

   always_comb begin
      higher_pend = 1'b0;
      for (int j = 0; j < ACT; j++) begin
         if (AW'(j) > d_ff && pend_v_ff[j]) begin
            higher_pend = 1'b1;
         end
      end
   end

   always_comb begin
      mul_a = {2'b00, scl_src} - {2'b00, start_ff};
      mul_b = {1'b0, eff};
      case (state_ff)
         ST_M1: begin
            mul_a = fld_ff ? {prev_rd_ff.angle[31], prev_rd_ff.angle}
                           : {prev_rd_ff.stamp[31], prev_rd_ff.stamp};
            mul_b = mcts_pkg::MUL_B_W'(s_int - k_ff);
         end
         ST_M2: begin
            mul_a = fld_ff ? {pend_rd_ff.angle[31], pend_rd_ff.angle}
                           : {pend_rd_ff.stamp[31], pend_rd_ff.stamp};
            mul_b = mcts_pkg::MUL_B_W'(k_ff);
         end
         default: begin
         end
      endcase
   end
   assign mul_p = mul_a * mul_b;

   // Truncation toward zero of the signed Q38.8 product, then saturation.
   assign rnd = prod_ff[mcts_pkg::PROD_W-1] ? prod_ff + mcts_pkg::PROD_W'(255) : prod_ff;
   assign shq = rnd[mcts_pkg::PROD_W-1:8];
   always_comb begin
      if (shq > $signed(38'sh007FFFFFFF)) begin
         sat = 32'h7FFF_FFFF;
      end else if (shq < $signed(-38'sh0080000000)) begin
         sat = 32'h8000_0000;
      end else begin
         sat = shq[31:0];
      end
   end

   assign acc_neg = acc_ff[mcts_pkg::ACC_W-1];
   assign acc_mag = acc_neg ? -acc_ff : acc_ff;
   assign div_sv  = acc_neg ? -div_q : div_q;

   mcts_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (acc_mag[mcts_pkg::DIV_W-1:0]),
      .divisor  (s_int),
      .done     (div_done),
      .quotient (div_q)
   );

   always_comb begin
      state_in      = state_ff;
      id_in         = id_ff;
      stamp_in      = stamp_ff;
      angle_in      = angle_ff;
      start_in      = start_ff;
      start_seen_in = start_seen_ff;
      init_in       = init_ff;
      init_seen_in  = init_seen_ff;
      prev_v_in     = prev_v_ff;
      pend_v_in     = pend_v_ff;
      phase_in      = phase_ff;
      ts_in         = ts_ff;
      prod_in       = prod_ff;
      acc_in        = acc_ff;
      k_in          = k_ff;
      d_in          = d_ff;
      fld_in        = fld_ff;
      eos_in        = eos_ff;
      ret_in        = ret_ff;
      em_dev_in     = em_dev_ff;
      em_st_in      = em_st_ff;
      em_an_in      = em_an_ff;
      em_last_in    = em_last_ff;
      rv_in         = rv_ff && rsp_stall;
      rdev_in       = rdev_ff;
      rst_in        = rst_ff;
      ran_in        = ran_ff;
      rlast_in      = rlast_ff;
      prev_we       = 1'b0;
      pend_we       = 1'b0;
      prev_wa       = id_ff[AW-1:0];
      pend_wa       = id_ff[AW-1:0];
      prev_wd       = {ts_ff, angle_ff};
      pend_wd       = {ts_ff, angle_ff};
      div_start     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               id_in    = req_device_id;
               stamp_in = req_stamp;
               angle_in = req_angle;
               k_in     = mcts_pkg::STEP_W'(1);
               d_in     = '0;
               if (req_mode) begin
                  eos_in = 1'b1;
                  if (interp_ff) begin
                     state_in = ST_SCAN;
                  end else begin
                     start_seen_in = 1'b0;
                     init_seen_in  = 1'b0;
                     start_in      = '0;
                     init_in       = '0;
                     prev_v_in     = '0;
                     pend_v_in     = '0;
                  end
               end else if ({1'b0, req_device_id} < 4'(ACT)) begin
                  eos_in = 1'b0;
                  if (!start_seen_ff) begin
                     start_in      = req_stamp;
                     start_seen_in = 1'b1;
                  end
                  state_in = ST_DEC;
               end
            end
         end
         ST_DEC: begin
            phase_in = PH_NORM;
            if (interp_ff && !prev_v_ff[id_ff[AW-1:0]]) begin
               init_in      = init_eff;
               init_seen_in = 1'b1;
               phase_in     = (init_eff != stamp_ff) ? PH_MISS : PH_EQ;
            end
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            prod_in  = mul_p;
            state_in = ST_SAT;
         end
         ST_SAT: begin
            ts_in = sat;
            case (phase_ff)
               PH_MISS: begin
                  prev_we  = 1'b1;
                  prev_wd  = {sat, angle_ff};
                  prev_v_in[id_ff[AW-1:0]] = 1'b1;
                  phase_in = PH_NORM;
                  state_in = ST_SCALE;
               end
               PH_EQ: begin
                  prev_we  = 1'b1;
                  prev_wd  = {sat, angle_ff};
                  prev_v_in[id_ff[AW-1:0]] = 1'b1;
                  em_dev_in  = id_ff;
                  em_st_in   = sat;
                  em_an_in   = angle_ff;
                  em_last_in = 1'b1;
                  ret_in     = RET_DONE;
                  state_in   = ST_EMIT;
               end
               default: begin
                  if (interp_ff) begin
                     state_in = pend_v_ff[id_ff[AW-1:0]] ? ST_SCAN : ST_PEND;
                  end else begin
                     em_dev_in  = id_ff;
                     em_st_in   = sat;
                     em_an_in   = angle_ff;
                     em_last_in = 1'b1;
                     ret_in     = RET_DONE;
                     state_in   = ST_EMIT;
                  end
               end
            endcase
         end
         ST_SCAN: begin
            if (pend_v_ff[d_ff]) begin
               if (final_pass) begin
                  // The pending command goes out and becomes the last one.
                  prev_we    = 1'b1;
                  prev_wa    = d_ff;
                  prev_wd    = pend_rd_ff;
                  prev_v_in[d_ff] = 1'b1;
                  pend_v_in[d_ff] = 1'b0;
                  em_dev_in  = mcts_pkg::DEV_W'(d_ff);
                  em_st_in   = pend_rd_ff.stamp;
                  em_an_in   = pend_rd_ff.angle;
                  em_last_in = !higher_pend;
                  ret_in     = RET_FLUSH;
                  state_in   = ST_EMIT;
               end else begin
                  fld_in   = 1'b0;
                  state_in = ST_M1;
               end
            end else begin
               state_in = ST_NEXT;
            end
         end
         ST_M1: begin
            acc_in   = mcts_pkg::ACC_W'(mul_p);
            state_in = ST_M2;
         end
         ST_M2: begin
            acc_in   = acc_ff + mcts_pkg::ACC_W'(mul_p);
            state_in = ST_DIVS;
         end
         ST_DIVS: begin
            div_start = 1'b1;
            state_in  = ST_DIVW;
         end
         ST_DIVW: begin
            if (div_done) begin
               if (!fld_ff) begin
                  em_st_in = div_sv[31:0];
                  fld_in   = 1'b1;
                  state_in = ST_M1;
               end else begin
                  em_an_in   = div_sv[31:0];
                  em_dev_in  = mcts_pkg::DEV_W'(d_ff);
                  em_last_in = 1'b0;
                  ret_in     = RET_FLUSH;
                  state_in   = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rv_in    = 1'b1;
               rdev_in  = em_dev_ff;
               rst_in   = em_st_ff;
               ran_in   = em_an_ff;
               rlast_in = em_last_ff;
               state_in = (ret_ff == RET_FLUSH) ? ST_NEXT : ST_IDLE;
            end
         end
         ST_NEXT: begin
            if (d_ff == AW'(ACT - 1)) begin
               d_in = '0;
               if (final_pass) begin
                  if (eos_ff) begin
                     start_seen_in = 1'b0;
                     init_seen_in  = 1'b0;
                     start_in      = '0;
                     init_in       = '0;
                     prev_v_in     = '0;
                     pend_v_in     = '0;
                     state_in      = ST_IDLE;
                  end else begin
                     state_in = ST_PEND;
                  end
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = ST_SCAN;
               end
            end else begin
               d_in     = d_ff + 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_PEND: begin
            pend_we  = 1'b1;
            pend_v_in[id_ff[AW-1:0]] = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff      <= 12'd512;
         interp_ff     <= 1'b0;
         state_ff      <= ST_IDLE;
         start_seen_ff <= 1'b0;
         init_seen_ff  <= 1'b0;
         start_ff      <= '0;
         init_ff       <= '0;
         prev_v_ff     <= '0;
         pend_v_ff     <= '0;
         rv_ff         <= 1'b0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               mcts_pkg::CSR_SCALE:  scale_ff  <= csr_wdata;
               mcts_pkg::CSR_INTERP: interp_ff <= csr_wdata[0];
               default: begin
               end
            endcase
         end
         state_ff      <= state_in;
         start_seen_ff <= start_seen_in;
         init_seen_ff  <= init_seen_in;
         start_ff      <= start_in;
         init_ff       <= init_in;
         prev_v_ff     <= prev_v_in;
         pend_v_ff     <= pend_v_in;
         rv_ff         <= rv_in;
      end
      id_ff      <= id_in;
      stamp_ff   <= stamp_in;
      angle_ff   <= angle_in;
      phase_ff   <= phase_in;
      ts_ff      <= ts_in;
      prod_ff    <= prod_in;
      acc_ff     <= acc_in;
      k_ff       <= k_in;
      d_ff       <= d_in;
      fld_ff     <= fld_in;
      eos_ff     <= eos_in;
      ret_ff     <= ret_in;
      em_dev_ff  <= em_dev_in;
      em_st_ff   <= em_st_in;
      em_an_ff   <= em_an_in;
      em_last_ff <= em_last_in;
      rdev_ff    <= rdev_in;
      rst_ff     <= rst_in;
      ran_ff     <= ran_in;
      rlast_ff   <= rlast_in;
   end

   always_ff @(posedge clock) begin
      if (prev_we) begin
         prev_mem[prev_wa] <= prev_wd;
      end
      if (pend_we) begin
         pend_mem[pend_wa] <= pend_wd;
      end
      prev_rd_ff <= prev_mem[d_in];
      pend_rd_ff <= pend_mem[d_in];
   end

   assign rsp_valid       = rv_ff;
   assign rsp_out_device  = rdev_ff;
   assign rsp_out_stamp   = rst_ff;
   assign rsp_out_angle   = ran_ff;
   assign rsp_last_of_run = rlast_ff;

endmodule

// File: tb/motion_command_time_scaler_test.sv
// ----------------------------------------------------------------------------
// Motion command time scaler testbench
// Drives directed and random command streams through the scaler under several
// scale and interpolation settings, with bursty requests and a stalling
// receiver, and checks every result against a predictor of the block.
// ----------------------------------------------------------------------------
module motion_command_time_scaler_test;

   localparam bit MODE_CMD = 1'b0;
   localparam bit MODE_END = 1'b1;
   localparam int NDEV = 8;

   typedef struct {
      logic [mcts_pkg::DEV_W-1:0]  dev;
      logic [mcts_pkg::DATA_W-1:0] stamp;
      logic [mcts_pkg::DATA_W-1:0] angle;
      bit                          last;
   } emitted_cmd;

   typedef struct {
      bit                           is_cfg;
      logic                         cfg_index;
      logic [mcts_pkg::SCALE_W-1:0] cfg_value;
      bit                           mode;
      logic [mcts_pkg::DEV_W-1:0]   dev;
      logic [mcts_pkg::STAMP_W-1:0] stamp;
      logic [mcts_pkg::DATA_W-1:0]  angle;
      bit                           typed;
      logic [mcts_pkg::DATA_W-1:0]  typed_stamp;
   } step_row;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_stall;
   logic                                req_mode = 1'b0;
   logic [mcts_pkg::DEV_W-1:0]          req_device_id = '0;
   logic [mcts_pkg::STAMP_W-1:0]        req_stamp = '0;
   logic signed [mcts_pkg::DATA_W-1:0]  req_angle = '0;
   logic                                rsp_valid;
   logic                                rsp_stall = 1'b0;
   logic [mcts_pkg::DEV_W-1:0]          rsp_out_device;
   logic signed [mcts_pkg::DATA_W-1:0]  rsp_out_stamp;
   logic signed [mcts_pkg::DATA_W-1:0]  rsp_out_angle;
   logic                                rsp_last_of_run;
   logic                                csr_write = 1'b0;
   logic                                csr_index = 1'b0;
   logic [mcts_pkg::SCALE_W-1:0]        csr_wdata = '0;

   motion_command_time_scaler DUT (.*);

   // Predictor state and register copies.
   logic [mcts_pkg::SCALE_W-1:0] scale_reg = 12'd512;
   logic                         interp_reg = 1'b0;
   logic [mcts_pkg::STAMP_W-1:0] start_stamp, init_stamp;
   bit                           start_seen, init_seen;
   bit                           last_valid [NDEV];
   longint                       last_stamp [NDEV], last_angle [NDEV];
   bit                           next_valid [NDEV];
   longint                       next_stamp [NDEV], next_angle [NDEV];

   emitted_cmd expected_cmds [$];
   int         errors = 0;
   int         burst_left = 0;
   bit         hold_request = 0;
   logic [mcts_pkg::STAMP_W-1:0] stamp_base;

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #20000000;
      $display("motion_command_time_scaler_test failed");
      $finish;
   end

   function automatic void clear_stream();
      start_stamp = '0; start_seen = 0;
      init_stamp = '0;  init_seen = 0;
      for (int d = 0; d < NDEV; d++) begin
         last_valid[d] = 0;
         next_valid[d] = 0;
      end
   endfunction

   function automatic longint scaled_time(logic [mcts_pkg::STAMP_W-1:0] t);
      longint diff, prod, eff;
      eff = (scale_reg > mcts_pkg::SCALE_MAX) ? 2048 : longint'(scale_reg);
      diff = longint'(t) - longint'(start_stamp);
      prod = (diff * eff) / 256;
      if (prod > 64'sd2147483647) prod = 64'sd2147483647;
      if (prod < -64'sd2147483648) prod = -64'sd2147483648;
      return prod;
   endfunction

   function automatic void push_cmd(int dev, longint st, longint an);
      emitted_cmd c;
      c.dev = dev[mcts_pkg::DEV_W-1:0];
      c.stamp = st[mcts_pkg::DATA_W-1:0];
      c.angle = an[mcts_pkg::DATA_W-1:0];
      c.last = 0;
      expected_cmds.push_back(c);
   endfunction

   function automatic void flush_frame();
      longint steps, st, an;
      steps = ((scale_reg > mcts_pkg::SCALE_MAX) ? 2048 : longint'(scale_reg)) >> 8;
      for (longint k = 1; k < steps; k++)
         for (int d = 0; d < NDEV; d++)
            if (next_valid[d]) begin
               st = (last_stamp[d] * (steps - k) + next_stamp[d] * k) / steps;
               an = (last_angle[d] * (steps - k) + next_angle[d] * k) / steps;
               push_cmd(d, st, an);
            end
      for (int d = 0; d < NDEV; d++)
         if (next_valid[d]) begin
            push_cmd(d, next_stamp[d], next_angle[d]);
            last_stamp[d] = next_stamp[d];
            last_angle[d] = next_angle[d];
            last_valid[d] = 1;
            next_valid[d] = 0;
         end
   endfunction

   function automatic void predict_request(bit mode, logic [mcts_pkg::DEV_W-1:0] dev,
                                           logic [mcts_pkg::STAMP_W-1:0] stamp,
                                           logic signed [mcts_pkg::DATA_W-1:0] angle);
      int     first;
      longint ts;
      bit     emitted_now;
      first = expected_cmds.size();
      emitted_now = 0;
      if (mode == MODE_END) begin
         if (interp_reg)
            for (int d = 0; d < NDEV; d++)
               if (next_valid[d]) push_cmd(d, next_stamp[d], next_angle[d]);
         clear_stream();
      end else begin
         if (!start_seen) begin
            start_stamp = stamp;
            start_seen = 1;
         end
         if (interp_reg && !last_valid[dev]) begin
            if (!init_seen) begin
               init_stamp = stamp;
               init_seen = 1;
            end
            // A late first command is backfilled at the initial time.
            if (init_stamp != stamp) begin
               last_stamp[dev] = scaled_time(init_stamp);
            end else begin
               last_stamp[dev] = scaled_time(stamp);
               push_cmd(dev, last_stamp[dev], angle);
               emitted_now = 1;
            end
            last_angle[dev] = angle;
            last_valid[dev] = 1;
         end
         if (!emitted_now) begin
            ts = scaled_time(stamp);
            if (interp_reg) begin
               if (next_valid[dev]) flush_frame();
               next_stamp[dev] = ts;
               next_angle[dev] = angle;
               next_valid[dev] = 1;
            end else begin
               push_cmd(dev, ts, angle);
            end
         end
      end
      if (expected_cmds.size() > first) expected_cmds[$].last = 1;
   endfunction

   task automatic send_request(bit mode, logic [mcts_pkg::DEV_W-1:0] dev,
                               logic [mcts_pkg::STAMP_W-1:0] stamp,
                               logic [mcts_pkg::DATA_W-1:0] angle);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = $urandom_range(1, 20);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_mode <= mode;
      req_device_id <= dev;
      req_stamp <= stamp;
      req_angle <= angle;
      do @(posedge clock); while (req_stall);
      predict_request(mode, dev, stamp, angle);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_cmds.size() != 0) @(posedge clock);
      // Requests that cause no result may still be in flight.
      repeat (50) @(posedge clock);
   endtask

   task automatic write_reg(logic index, logic [mcts_pkg::SCALE_W-1:0] value);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      @(posedge clock);
      if (index == mcts_pkg::CSR_SCALE) scale_reg = value;
      else interp_reg = value[0];
   endtask

   // Result checker.
   always @(posedge clock) begin
      emitted_cmd e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_cmds.size() == 0) begin
            $error("result with nothing expected: device %0d stamp %0d",
                   rsp_out_device, rsp_out_stamp);
            errors++;
         end else begin
            e = expected_cmds.pop_front();
            if (rsp_out_device !== e.dev) begin
               $error("out_device: expected %0d, got %0d", e.dev, rsp_out_device);
               errors++;
            end
            if (rsp_out_stamp !== e.stamp) begin
               $error("out_stamp: expected %0d, got %0d", $signed(e.stamp), rsp_out_stamp);
               errors++;
            end
            if (rsp_out_angle !== e.angle) begin
               $error("out_angle: expected %0d, got %0d", $signed(e.angle), rsp_out_angle);
               errors++;
            end
            if (rsp_last_of_run !== e.last) begin
               $error("last_of_run: expected %0d, got %0d", e.last, rsp_last_of_run);
               errors++;
            end
         end
      end
   end

   // Receiver: switches among three stall styles, and holds off once for
   // a long stretch when asked so that the block backs up.
   initial begin
      int style;
      int cycle;
      cycle = 0;
      style = 0;
      forever begin
         @(posedge clock);
         cycle++;
         if (hold_request) begin
            hold_request = 0;
            rsp_stall <= 1'b1;
            repeat (600) @(posedge clock);
         end
         if (cycle % 64 == 0) style = $urandom_range(0, 2);
         case (style)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 2) == 0);
            default: rsp_stall <= (cycle % 4 == 0);
         endcase
      end
   end

   step_row directed [31] = '{
      '{0, mcts_pkg::CSR_SCALE, 0, MODE_CMD, 0, 1000,         32'h0000_0000, 1, 32'd0},
      '{0, mcts_pkg::CSR_SCALE, 0, MODE_CMD, 7, 2000,         32'h7FFF_FFFF, 1, 32'd2000},
      '{0, mcts_pkg::CSR_SCALE, 0, MODE_CMD, 3, 0,            32'h8000_0000, 1,
        32'hFFFF_F830},
      '{0, mcts_pkg::CSR_SCALE, 0, MODE_CMD, 1, 31'h7FFFFFFF, 32'hFFFF_FFFF, 1,
        32'h7FFF_FFFF},
      '{0, mcts_pkg::CSR_SCALE, 0, MODE_END, 5, 31'h7FFFFFFF, 32'h0000_0000, 0, 32'd0},
      '{0, mcts_pkg::CSR_SCALE, 0, MODE_CMD, 2, 0,            32'h0000_0005, 1, 32'd0},
      '{0, mcts_pkg::CSR_SCALE, 0, MODE_CMD, 6, 31'h7FFFFFFF, 32'h0000_1234, 1,
        32'h7FFF_FFFF},
      '{0, mcts_pkg::CSR_SCALE, 0, MODE_END, 0, 0,            32'h0000_0000, 0, 32'd0},
      '{1, mcts_pkg::CSR_SCALE, 12'd0, MODE_CMD, 0, 0,        32'h0000_0000, 0, 32'd0},
      '{0, mcts_pkg::CSR_SCALE, 0, MODE_CMD, 4, 500,          32'h0000_0063, 1, 32'd0},
      '{0, mcts_pkg::CSR_SCALE, 0, MODE_CMD, 4, 9000,         32'hFFFF_FFF9, 1, 32'd0},
      '{0, mcts_pkg::CSR_SCALE, 0, MODE_END, 0, 0,            32'h0000_0000, 0, 32'd0},
      '{1, mcts_pkg::CSR_INTERP, 12'd1, MODE_CMD, 0, 0,       32'h0000_0000, 0, 32'd0},
      '{1, mcts_pkg::CSR_SCALE, 12'h300, MODE_CMD, 0, 0,      32'h0000_0000, 0, 32'd0},
      '{0, mcts_pkg::CSR_SCALE, 0, MODE_CMD, 0, 100,          32'h0000_0000, 1, 32'd0},
      '{0, mcts_pkg::CSR_SCALE, 0, MODE_CMD, 1, 150,          32'h0000_03E8, 0, 32'd0},
      '{0, mcts_pkg::CSR_SCALE, 0, MODE_CMD, 0, 200,          32'h0000_0BB8, 0, 32'd0},
      '{0, mcts_pkg::CSR_SCALE, 0, MODE_CMD, 0, 300,          32'hFFFF_F448, 0, 32'd0},
      '{0, mcts_pkg::CSR_SCALE, 0, MODE_CMD, 1, 400,          32'h7FFF_FFFF, 0, 32'd0},
      '{0, mcts_pkg::CSR_SCALE, 0, MODE_END, 0, 0,            32'h0000_0000, 0, 32'd0},
      '{1, mcts_pkg::CSR_SCALE, 12'hFFF, MODE_CMD, 0, 0,      32'h0000_0000, 0, 32'd0},
      '{0, mcts_pkg::CSR_SCALE, 0, MODE_CMD, 0, 10,           32'h0001_0000, 1, 32'd0},
      '{0, mcts_pkg::CSR_SCALE, 0, MODE_CMD, 1, 11,           32'h8000_0000, 0, 32'd0},
      '{0, mcts_pkg::CSR_SCALE, 0, MODE_CMD, 2, 12,           32'h7FFF_FFFF, 0, 32'd0},
      '{0, mcts_pkg::CSR_SCALE, 0, MODE_CMD, 3, 13,           32'hFFFE_0000, 0, 32'd0},
      '{0, mcts_pkg::CSR_SCALE, 0, MODE_CMD, 4, 14,           32'h0005_8000, 0, 32'd0},
      '{0, mcts_pkg::CSR_SCALE, 0, MODE_CMD, 5, 15,           32'hC000_0001, 0, 32'd0},
      '{0, mcts_pkg::CSR_SCALE, 0, MODE_CMD, 6, 16,           32'h1234_5678, 0, 32'd0},
      '{0, mcts_pkg::CSR_SCALE, 0, MODE_CMD, 7, 17,           32'h0000_0001, 0, 32'd0},
      '{0, mcts_pkg::CSR_SCALE, 0, MODE_CMD, 0, 20,           32'hFFFF_FFFF, 0, 32'd0},
      '{0, mcts_pkg::CSR_SCALE, 0, MODE_CMD, 0, 30,           32'h4000_0000, 0, 32'd0}
   };

   initial begin
      emitted_cmd typed_cmd;
      int sent;
      int phase_len;
      int pick;
      bit mode;
      logic [mcts_pkg::DEV_W-1:0] dev;
      logic [mcts_pkg::STAMP_W-1:0] stamp;
      logic [mcts_pkg::SCALE_W-1:0] scale;

      clear_stream();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) begin
         if (directed[i].is_cfg) begin
            wait_idle();
            write_reg(directed[i].cfg_index, directed[i].cfg_value);
         end else begin
            send_request(directed[i].mode, directed[i].dev, directed[i].stamp,
                         directed[i].angle);
            if (directed[i].typed) begin
               // Results simple enough to read straight off the request.
               void'(expected_cmds.pop_back());
               typed_cmd.dev = directed[i].dev;
               typed_cmd.stamp = directed[i].typed_stamp;
               typed_cmd.angle = directed[i].angle;
               typed_cmd.last = 1;
               expected_cmds.push_back(typed_cmd);
            end
         end
      end
      send_request(MODE_END, 0, 0, 0);
      wait_idle();

      sent = 0;
      stamp_base = 0;
      while (sent < 500) begin
         pick = $urandom_range(0, 9);
         case (pick)
            0: scale = 12'd0;
            1: scale = 12'hFFF;
            2: scale = mcts_pkg::SCALE_MAX;
            3: scale = 12'd256;
            default: scale = mcts_pkg::SCALE_W'($urandom_range(1, 1023));
         endcase
         write_reg(mcts_pkg::CSR_SCALE, scale);
         write_reg(mcts_pkg::CSR_INTERP, mcts_pkg::SCALE_W'($urandom_range(0, 3) != 0));
         if (sent == 0) hold_request = 1;
         phase_len = $urandom_range(20, 60);
         repeat (phase_len) begin
            mode = MODE_CMD;
            dev = mcts_pkg::DEV_W'($urandom_range(0, NDEV - 1));
            if ($urandom_range(0, 19) == 0) begin
               mode = 1'($urandom_range(0, 1));
               stamp = mcts_pkg::STAMP_W'($urandom);
            end else if ($urandom_range(0, 24) == 0) begin
               mode = MODE_END;
               stamp = mcts_pkg::STAMP_W'($urandom);
            end else begin
               if ($urandom_range(0, 15) == 0) stamp_base = mcts_pkg::STAMP_W'($urandom);
               stamp_base = stamp_base + mcts_pkg::STAMP_W'($urandom_range(0, 300));
               stamp = stamp_base;
            end
            send_request(mode, dev, stamp, $urandom);
            sent++;
         end
         if ($urandom_range(0, 1)) send_request(MODE_END, 0, 0, 0);
         wait_idle();
      end

      if (errors == 0) begin
         $display("motion_command_time_scaler_test passed");
      end else begin
         $display("motion_command_time_scaler_test failed");
      end
      $finish;
   end

endmodule

// File: files.f
design/mcts_pkg.sv
design/mcts_div.sv
design/motion_command_time_scaler.sv
tb/motion_command_time_scaler_test.sv
